@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clock, masked while reset is high.
`define LPHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define LPHT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/lpht_pkg.sv @@
// ---------------------------------------------------------------------------
// lpht_pkg
// Types and constants of the linear-probe hash table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

   localparam int unsigned KEY_W    = 31;
   localparam int unsigned VAL_W    = 32;
   localparam int unsigned STATUS_W = 3;

   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_READ_HIT  = 3'd0,
      STATUS_READ_MISS = 3'd1,
      STATUS_WRITE_UPD = 3'd2,
      STATUS_WRITE_INS = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_KEY,
      ST_HASH_SLOT,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } slot_entry_type;

   // write port of the slot memory
   typedef struct packed {
      logic           en;
      slot_entry_type data;
   } slot_wr_type;

endpackage

@@ hdl/lpht_req_if.sv @@
// ---------------------------------------------------------------------------
// lpht_req_if
// Command channel: valid/ready plus command, key and write value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpht_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [lpht_pkg::KEY_W-1:0]     lookup_key;
   logic signed [lpht_pkg::VAL_W-1:0] write_value;

   modport source (output valid, output command, output lookup_key,
                   output write_value, input ready);
   modport sink   (input valid, input command, input lookup_key,
                   input write_value, output ready);
endinterface

@@ hdl/lpht_rsp_if.sv @@
// ---------------------------------------------------------------------------
// lpht_rsp_if
// Result channel: valid/ready plus status and value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpht_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lpht_pkg::STATUS_W-1:0]     status;
   logic signed [lpht_pkg::VAL_W-1:0] read_value;

   modport source (output valid, output status, output read_value, input ready);
   modport sink   (input valid, input status, input read_value, output ready);
endinterface

@@ hdl/lpht_rem.sv @@
// ---------------------------------------------------------------------------
// lpht_rem
// Remainder by a constant: reciprocal multiply into prod_ff, then multiply
// back and subtract into rem_ff. DIVIDEND_W must be at least $clog2(DIVISOR).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_rem #(
   parameter int unsigned DIVIDEND_W = 31,
   parameter int unsigned DIVISOR    = 20,
   parameter int unsigned REM_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic                  done,
   output logic [REM_W-1:0]      remainder
);

   // quotient = (x * RECIP) >> SHIFT, exact for every x below 2**DIVIDEND_W
   localparam int unsigned LOG_D   = $clog2(DIVISOR);
   localparam int unsigned DIV_W   = $clog2(DIVISOR + 1);
   localparam int unsigned SHIFT   = DIVIDEND_W + LOG_D;
   localparam int unsigned RECIP_W = DIVIDEND_W + 1;
   localparam int unsigned PROD_W  = DIVIDEND_W + RECIP_W;
   localparam int unsigned QUOT_W  = PROD_W - SHIFT;
   localparam int unsigned CALC_W  = DIVIDEND_W + DIV_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic                  stage_ff, stage_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] x_ff, x_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [REM_W-1:0]      rem_ff, rem_in;

   logic [QUOT_W-1:0]     quot;
   logic [CALC_W-1:0]     diff;

   assign quot = prod_ff[PROD_W-1:SHIFT];
   assign diff = CALC_W'(x_ff) - CALC_W'(quot) * CALC_W'(DIVISOR);

   always_comb begin
      stage_in = start;
      done_in  = stage_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      if (start) begin
         x_in    = dividend;
         prod_in = PROD_W'(dividend) * PROD_W'(RECIP);
      end
      if (stage_ff) begin
         rem_in = diff[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ hdl/lpht_slot_mem.sv @@
// ---------------------------------------------------------------------------
// lpht_slot_mem
// Slot store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_slot_mem #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic                           clock,
   input  lpht_pkg::slot_wr_type          wr,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [ADDR_W-1:0]              rd_addr,
   output lpht_pkg::slot_entry_type       rd_data
);

   lpht_pkg::slot_entry_type slot_mem_ff [DEPTH];
   lpht_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem_ff[wr_addr] <= wr.data;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/linear_probe_hash_table_unit.sv @@
// ---------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Key/value table of SLOTS entries, open addressing with linear probing.
// A read returns the value stored for the key (status read hit) or -1 with
// status read miss. A write updates a matching key (write updated), claims
// the first empty slot on its probe path (write inserted), or, when every
// slot holds another key, is dropped with status table full; writes echo
// their value. There is no delete. One command is in flight at a time:
// the home slot (key mod HASH_MOD) mod SLOTS comes from two remainder
// units in turn, each a reciprocal multiply then a multiply back and
// subtract, then the probe loop reads one slot per cycle from the slot
// memory, P probes with P from 1 to SLOTS, and ST_DONE loads the output
// register. The next command is accepted once that load is done. A
// finished response sits in the output register, so the next command
// is taken while it waits; a second finished response stalls until
// that register drains. After reset a clearing pass writes every slot
// in turn and zeroes the valid marks in memory; req_port.ready stays
// low until it ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_probe_hash_table_unit #(
   parameter int unsigned SLOTS    = 16,
   parameter int unsigned HASH_MOD = 20
) (
   input  logic             clock,
   input  logic             reset,
   lpht_req_if.sink         req_port,
   lpht_rsp_if.source       rsp_port
);

   localparam int unsigned IDX_W     = $clog2(SLOTS);
   localparam int unsigned CNT_W     = $clog2(SLOTS + 1);
   localparam int unsigned MOD_REM_W = (HASH_MOD > 1) ? $clog2(HASH_MOD) : 1;
   localparam int unsigned FOLD_W    = (MOD_REM_W > IDX_W) ? MOD_REM_W : IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // ---- control state ----
   lpht_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;

   // ---- command being served ----
   lpht_pkg::command_type         cmd_ff, cmd_in;
   logic [lpht_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [lpht_pkg::VAL_W-1:0]    val_ff, val_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;      // slot whose data is on rd_data
   logic [CNT_W-1:0]              cnt_ff, cnt_in;      // probes already made
   lpht_pkg::status_type          res_status_ff, res_status_in;
   logic [lpht_pkg::VAL_W-1:0]    res_value_ff, res_value_in;

   // ---- output register ----
   logic                          rsp_valid_ff, rsp_valid_in;
   lpht_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [lpht_pkg::VAL_W-1:0]    rsp_value_ff, rsp_value_in;

   // ---- remainder units ----
   logic                           mod_start;
   logic                           mod_done;
   logic [MOD_REM_W-1:0]           mod_result;
   logic                           slot_start;
   logic                           slot_done;
   logic [FOLD_W-1:0]              fold_dividend;
   logic [IDX_W-1:0]               slot_result;

   // ---- slot memory ----
   lpht_pkg::slot_wr_type          mem_wr;
   logic [IDX_W-1:0]               mem_wr_addr;
   logic [IDX_W-1:0]               mem_rd_addr;
   lpht_pkg::slot_entry_type       mem_rd_data;

   logic                           key_match;
   logic                           last_probe;
   logic                           rsp_load;
   logic [IDX_W-1:0]               idx_next;

   // key mod HASH_MOD, straight from the command bus at accept
   lpht_rem #(
      .DIVIDEND_W (lpht_pkg::KEY_W),
      .DIVISOR    (HASH_MOD),
      .REM_W      (MOD_REM_W)
   ) u_rem_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_port.lookup_key),
      .done      (mod_done),
      .remainder (mod_result)
   );

   // folds the first remainder into the slot range
   lpht_rem #(
      .DIVIDEND_W (FOLD_W),
      .DIVISOR    (SLOTS),
      .REM_W      (IDX_W)
   ) u_rem_slot (
      .clock     (clock),
      .reset     (reset),
      .start     (slot_start),
      .dividend  (fold_dividend),
      .done      (slot_done),
      .remainder (slot_result)
   );

   lpht_slot_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .wr_addr (mem_wr_addr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign fold_dividend = FOLD_W'(mod_result);
   assign key_match  = mem_rd_data.valid && (mem_rd_data.key == key_ff);
   assign last_probe = (cnt_ff == CNT_W'(SLOTS - 1));
   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

   // Next state and datapath control. Memory reads are issued one slot
   // ahead, so each cycle in ST_PROBE checks one slot. A write lands in
   // ST_PROBE and the next command's first read comes two hash passes
   // later, so the read-after-write hazard cannot occur.
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_load      = 1'b0;

      req_port.ready = 1'b0;

      mod_start  = 1'b0;
      slot_start = 1'b0;

      mem_wr.en         = 1'b0;
      mem_wr.data.valid = 1'b1;
      mem_wr.data.key   = key_ff;
      mem_wr.data.value = val_ff;
      mem_wr_addr       = idx_ff;
      mem_rd_addr       = idx_ff;

      unique case (state_ff)
         lpht_pkg::ST_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.data = '0;
            mem_wr_addr = clr_idx_ff;
            clr_idx_in  = (clr_idx_ff == LAST_IDX) ? '0 : clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = lpht_pkg::ST_IDLE;
            end
         end

         lpht_pkg::ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               cmd_in    = lpht_pkg::command_type'(req_port.command);
               key_in    = req_port.lookup_key;
               val_in    = req_port.write_value;
               mod_start = 1'b1;
               state_in  = lpht_pkg::ST_HASH_KEY;
            end
         end

         lpht_pkg::ST_HASH_KEY: begin
            // second pass folds key mod HASH_MOD into the slot range
            if (mod_done) begin
               slot_start = 1'b1;
               state_in   = lpht_pkg::ST_HASH_SLOT;
            end
         end

         lpht_pkg::ST_HASH_SLOT: begin
            mem_rd_addr = slot_result;
            if (slot_done) begin
               idx_in   = slot_result;
               cnt_in   = '0;
               state_in = lpht_pkg::ST_PROBE;
            end
         end

         lpht_pkg::ST_PROBE: begin
            mem_rd_addr = idx_next;
            if (cmd_ff == lpht_pkg::CMD_READ) begin
               priority if (key_match) begin
                  res_status_in = lpht_pkg::STATUS_READ_HIT;
                  res_value_in  = mem_rd_data.value;
                  state_in      = lpht_pkg::ST_DONE;
               end else if (last_probe) begin
                  res_status_in = lpht_pkg::STATUS_READ_MISS;
                  res_value_in  = lpht_pkg::MISS_VALUE;
                  state_in      = lpht_pkg::ST_DONE;
               end else begin
                  idx_in = idx_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               res_value_in = val_ff;
               priority if (!mem_rd_data.valid) begin
                  mem_wr.en     = 1'b1;
                  res_status_in = lpht_pkg::STATUS_WRITE_INS;
                  state_in      = lpht_pkg::ST_DONE;
               end else if (key_match) begin
                  mem_wr.en     = 1'b1;
                  res_status_in = lpht_pkg::STATUS_WRITE_UPD;
                  state_in      = lpht_pkg::ST_DONE;
               end else if (last_probe) begin
                  res_status_in = lpht_pkg::STATUS_FULL;
                  state_in      = lpht_pkg::ST_DONE;
               end else begin
                  idx_in = idx_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         lpht_pkg::ST_DONE: begin
            // hand over once the output register is free or draining
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_load = 1'b1;
               state_in = lpht_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lpht_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.status     = rsp_status_ff;
   assign rsp_port.read_value = rsp_value_ff;

   // ---- assertions ----
   `LPHT_ASSERT_ALWAYS(a_reset_clears, reset |=> state_ff == lpht_pkg::ST_CLEAR,
      "reset did not start the clearing pass")
   `LPHT_ASSERT(a_mod_done_in_hash, mod_done |-> state_ff == lpht_pkg::ST_HASH_KEY,
      "key remainder arrived outside its hash pass")
   `LPHT_ASSERT(a_slot_done_in_hash, slot_done |-> state_ff == lpht_pkg::ST_HASH_SLOT,
      "slot remainder arrived outside its hash pass")
   `LPHT_ASSERT(a_probe_bound, state_ff == lpht_pkg::ST_PROBE |-> cnt_ff < CNT_W'(SLOTS),
      "probe count ran past the table size")
   `LPHT_ASSERT(a_write_states,
      mem_wr.en |-> (state_ff == lpht_pkg::ST_CLEAR ||
                     (state_ff == lpht_pkg::ST_PROBE && cmd_ff == lpht_pkg::CMD_WRITE)),
      "slot memory written outside clear or a write probe")

endmodule
